@@ sv/stm_pkg.sv @@
`default_nettype none
package stm_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int VAL_W       = 32;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic KIND_LOADED = 1'b0;
    localparam logic KIND_ANSWER = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OUTER,
        ST_KEY,
        ST_INNER,
        ST_CMP,
        ST_PROBE,
        ST_PCMP,
        ST_EMIT
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_QUERY,
        DP_READ_KEY,
        DP_LATCH_KEY,
        DP_READ_PREV,
        DP_SHIFT,
        DP_PLACE,
        DP_SORT_DONE,
        DP_PROBE_READ,
        DP_PROBE_HIGH,
        DP_PROBE_LOW,
        DP_HIT,
        DP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   kind;
    } t_dp_cmd;

    typedef struct packed {
        logic sort_more;
        logic j_zero;
        logic greater;
        logic probe_more;
        logic equal;
        logic out_free;
    } t_dp_status;

endpackage
`default_nettype wire

@@ sv/stm_ram.sv @@
`default_nettype none
module stm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ sv/stm_ctrl.sv @@
`default_nettype none
module stm_ctrl
    import stm_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    input  wire logic       i_s_tuser,
    input  wire logic       i_s_tlast,
    input  wire logic       i_open,
    input  wire t_dp_status i_status,
    output logic            o_s_tready,
    output t_dp_cmd         o_cmd
);
    t_state r_state, n_state;
    logic   r_kind, n_kind;
    logic   w_accept;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_kind  <= KIND_LOADED;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_s_tuser == OP_LOAD) begin
                        n_kind = KIND_LOADED;
                        if (i_s_tlast) begin
                            n_state = ST_OUTER;
                        end
                    end else begin
                        n_kind  = KIND_ANSWER;
                        n_state = i_open ? ST_OUTER : ST_PROBE;
                    end
                end
            end
            ST_OUTER: begin
                if (i_status.sort_more) begin
                    n_state = ST_KEY;
                end else begin
                    n_state = (r_kind == KIND_ANSWER) ? ST_PROBE : ST_EMIT;
                end
            end
            ST_KEY:   n_state = ST_INNER;
            ST_INNER: n_state = i_status.j_zero ? ST_OUTER : ST_CMP;
            ST_CMP:   n_state = i_status.greater ? ST_INNER : ST_OUTER;
            ST_PROBE: n_state = i_status.probe_more ? ST_PCMP : ST_EMIT;
            ST_PCMP:  n_state = i_status.equal ? ST_EMIT : ST_PROBE;
            ST_EMIT: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd.op   = DP_NOP;
        o_cmd.kind = r_kind;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    o_cmd.op = (i_s_tuser == OP_LOAD) ? DP_LOAD : DP_QUERY;
                end
            end
            ST_OUTER: o_cmd.op = i_status.sort_more ? DP_READ_KEY : DP_SORT_DONE;
            ST_KEY:   o_cmd.op = DP_LATCH_KEY;
            ST_INNER: o_cmd.op = i_status.j_zero ? DP_PLACE : DP_READ_PREV;
            ST_CMP:   o_cmd.op = i_status.greater ? DP_SHIFT : DP_PLACE;
            ST_PROBE: o_cmd.op = i_status.probe_more ? DP_PROBE_READ : DP_NOP;
            ST_PCMP: begin
                if (i_status.equal) begin
                    o_cmd.op = DP_HIT;
                end else if (i_status.greater) begin
                    o_cmd.op = DP_PROBE_HIGH;
                end else begin
                    o_cmd.op = DP_PROBE_LOW;
                end
            end
            ST_EMIT:  o_cmd.op = i_status.out_free ? DP_EMIT : DP_NOP;
            default:  o_cmd.op = DP_NOP;
        endcase
    end
endmodule
`default_nettype wire

@@ sv/stm_dp.sv @@
`default_nettype none
module stm_dp
    import stm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    input  wire logic [VAL_W-1:0]  i_value,
    input  wire logic              i_m_tready,
    output t_dp_status             o_status,
    output logic                   o_open,
    output logic                   o_m_tvalid,
    output logic                   o_m_kind,
    output logic                   o_m_found,
    output logic [CNT_W-1:0]       o_m_count,
    output logic                   o_m_overflow
);
    logic              r_open, r_ovf, r_found, r_out_valid;
    logic [CNT_W-1:0]  r_count, r_i, r_lo, r_hi, r_mid;
    logic [ADDR_W-1:0] r_j;
    logic signed [VAL_W-1:0] r_key, r_target;
    logic              r_out_kind, r_out_found, r_out_ovf;
    logic [CNT_W-1:0]  r_out_count;

    logic              w_we;
    logic [ADDR_W-1:0] w_waddr, w_raddr;
    logic [VAL_W-1:0]  w_wdata, w_rdata;
    logic [CNT_W-1:0]  w_fill;
    logic [CNT_W:0]    w_sum;
    logic [CNT_W-1:0]  w_mid;

    stm_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // fill level seen by a load: a closed table restarts empty
    assign w_fill = r_open ? r_count : '0;
    assign w_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid  = w_sum[CNT_W:1];

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_j;
        w_wdata = r_key;
        w_raddr = r_mid[ADDR_W-1:0];
        case (i_cmd.op)
            DP_LOAD: begin
                w_we    = (w_fill < CNT_W'(TABLE_DEPTH));
                w_waddr = w_fill[ADDR_W-1:0];
                w_wdata = i_value;
            end
            DP_READ_KEY:   w_raddr = r_i[ADDR_W-1:0];
            DP_READ_PREV:  w_raddr = r_j - 1'b1;
            DP_SHIFT: begin
                w_we    = 1'b1;
                w_wdata = w_rdata;
            end
            DP_PLACE:      w_we = 1'b1;
            DP_PROBE_READ: w_raddr = w_mid[ADDR_W-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open      <= 1'b0;
            r_ovf       <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == DP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                DP_LOAD: begin
                    r_open <= 1'b1;
                    if (w_fill < CNT_W'(TABLE_DEPTH)) begin
                        r_count <= w_fill + 1'b1;
                        r_ovf   <= r_open & r_ovf;
                    end else begin
                        r_count <= w_fill;
                        r_ovf   <= 1'b1;
                    end
                end
                DP_SORT_DONE: r_open <= 1'b0;
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LOAD: begin
                r_i     <= CNT_W'(1);
                r_found <= 1'b0;
            end
            DP_QUERY: begin
                r_i      <= CNT_W'(1);
                r_lo     <= '0;
                r_hi     <= r_count;
                r_target <= i_value;
                r_found  <= 1'b0;
            end
            DP_LATCH_KEY: begin
                r_key <= w_rdata;
                r_j   <= r_i[ADDR_W-1:0];
            end
            DP_SHIFT:      r_j <= r_j - 1'b1;
            DP_PLACE:      r_i <= r_i + 1'b1;
            DP_PROBE_READ: r_mid <= w_mid;
            DP_PROBE_HIGH: r_hi <= r_mid;
            DP_PROBE_LOW:  r_lo <= r_mid + 1'b1;
            DP_HIT:        r_found <= 1'b1;
            DP_EMIT: begin
                r_out_kind  <= i_cmd.kind;
                r_out_found <= r_found;
                r_out_count <= r_count;
                r_out_ovf   <= r_ovf;
            end
            default: ;
        endcase
    end

    // compares against the word read in the previous cycle
    // an open table is being sorted against the key, a closed one searched
    always_comb begin
        o_status.sort_more  = (r_i < r_count);
        o_status.j_zero     = (r_j == '0);
        o_status.probe_more = (r_hi > r_lo);
        o_status.equal      = ($signed(w_rdata) == r_target);
        o_status.greater    = r_open ? ($signed(w_rdata) > r_key)
                                     : ($signed(w_rdata) > r_target);
        o_status.out_free   = !r_out_valid || i_m_tready;
    end

    assign o_open       = r_open;
    assign o_m_tvalid   = r_out_valid;
    assign o_m_kind     = r_out_kind;
    assign o_m_found    = r_out_found;
    assign o_m_count    = r_out_count;
    assign o_m_overflow = r_out_ovf;
endmodule
`default_nettype wire

@@ sv/sorted_table_membership_search.sv @@
`default_nettype none
// sorted table membership search. load words (tuser = 0) store signed 32-bit
// values in a 1024-entry table, one per cycle; the load word with tlast set
// closes the table, which is then insertion-sorted in place and a load-done
// word is returned. query words (tuser = 1) are answered by a binary search
// over the sorted table. a query that arrives while a table is still open
// sorts it first, with no load-done word. the sort walks the single-read-port
// table ram: each entry is read as the key, then each larger element before
// it is read, compared and shifted up one place, and the key is written into
// the gap. a query on a closed table is accepted, then reads and compares one
// word per probe, at most log2(count)+1 probes, then does the final range
// check and the result handoff. the input accepts only while the controller is idle; a
// finished result waits in the output register, so a following load can be
// taken before it is read.
module sorted_table_membership_search
    import stm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // value[31:0]
    input  wire logic        i_s_tuser,   // opcode
    input  wire logic        i_s_tlast,   // last load of the table
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata,   // found[0], entry_count[11:1], overflow[12]
    output logic             o_m_tuser    // result_kind
);
    t_dp_cmd           w_cmd;
    t_dp_status        w_status;
    logic              w_open;
    logic              w_found, w_ovf;
    logic [CNT_W-1:0]  w_count;

    // sequencer: load, sort passes, probes, result handoff
    stm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .i_open     (w_open),
        .i_status   (w_status),
        .o_s_tready (o_s_tready),
        .o_cmd      (w_cmd)
    );

    // table ram, sort and search registers, output register
    stm_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_value      (i_s_tdata),
        .i_m_tready   (i_m_tready),
        .o_status     (w_status),
        .o_open       (w_open),
        .o_m_tvalid   (o_m_tvalid),
        .o_m_kind     (o_m_tuser),
        .o_m_found    (w_found),
        .o_m_count    (w_count),
        .o_m_overflow (w_ovf)
    );

    assign o_m_tdata = {3'b000, w_ovf, w_count, w_found};
endmodule
`default_nettype wire

@@ sim/tb_sorted_table_membership_search.sv @@
`default_nettype none
module tb_sorted_table_membership_search;
    import stm_pkg::*;

    typedef struct packed {
        logic        op;
        logic [31:0] value;
        logic        last;
    } t_word_in;

    typedef struct packed {
        logic             kind;
        logic             found;
        logic [CNT_W-1:0] count;
        logic             ovf;
    } t_answer;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;
    logic        i_s_tuser;
    logic        i_s_tlast;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;
    logic        o_m_tuser;

    sorted_table_membership_search u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // predictor state
    logic signed [31:0] tbl_vals [TABLE_DEPTH];
    int                 tbl_cnt;
    logic               tbl_ovf;
    logic               tbl_open;

    t_word_in pending_words[$];
    t_answer  expected_answers[$];
    int       errors;
    bit       hold_off;
    bit       in_taken;
    int       idle_cycles;

    function automatic void sort_values();
        logic signed [31:0] key;
        int j;
        for (int i = 1; i < tbl_cnt; i++) begin
            key = tbl_vals[i];
            j = i;
            while (j > 0 && tbl_vals[j-1] > key) begin
                tbl_vals[j] = tbl_vals[j-1];
                j--;
            end
            tbl_vals[j] = key;
        end
    endfunction

    function automatic logic search_value(logic signed [31:0] target);
        int lo, hi, mid;
        lo = 0;
        hi = tbl_cnt;
        while (hi > lo) begin
            mid = lo + (hi - lo) / 2;
            if (tbl_vals[mid] == target) return 1'b1;
            if (tbl_vals[mid] > target) hi = mid;
            else lo = mid + 1;
        end
        return 1'b0;
    endfunction

    // update the table model for an accepted word, queue its answer if any
    function automatic void predict_word(t_word_in w);
        t_answer a;
        if (w.op == OP_LOAD) begin
            if (!tbl_open) begin
                tbl_cnt = 0;
                tbl_ovf = 1'b0;
                tbl_open = 1'b1;
            end
            if (tbl_cnt < TABLE_DEPTH) begin
                tbl_vals[tbl_cnt] = w.value;
                tbl_cnt++;
            end else begin
                tbl_ovf = 1'b1;
            end
            if (!w.last) return;
            sort_values();
            tbl_open = 1'b0;
            a.kind = KIND_LOADED;
            a.found = 1'b0;
        end else begin
            if (tbl_open) begin
                sort_values();
                tbl_open = 1'b0;
            end
            a.kind = KIND_ANSWER;
            a.found = search_value(w.value);
        end
        a.count = tbl_cnt[CNT_W-1:0];
        a.ovf = tbl_ovf;
        expected_answers.push_back(a);
    endfunction

    function automatic void add_word(logic op, logic [31:0] v, logic last);
        t_word_in w;
        w.op = op;
        w.value = v;
        w.last = last;
        pending_words.push_back(w);
    endfunction

    function automatic logic [31:0] pick_value(ref logic [31:0] pool[$]);
        if (pool.size() > 0 && $urandom_range(0, 2) != 0)
            return pool[$urandom_range(0, pool.size() - 1)];
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 40) - 20;
            default: return $urandom;
        endcase
    endfunction

    // driver: bursts of random length separated by random gaps
    int burst_left;
    int gap_left;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (i_s_tvalid && !in_taken) begin
            // hold the word until taken
        end else if (hold_off || pending_words.size() == 0) begin
            i_s_tvalid <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            i_s_tvalid <= 1'b0;
        end else begin
            i_s_tvalid <= 1'b1;
            i_s_tuser  <= pending_words[0].op;
            i_s_tdata  <= pending_words[0].value;
            i_s_tlast  <= pending_words[0].last;
            if (burst_left > 0) begin
                burst_left <= burst_left - 1;
            end else begin
                burst_left <= $urandom_range(0, 12);
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
        end
    end

    // receiver stall pattern: long ready stretches, a regular toggling stretch and random stalls
    int stall_phase;
    always @(negedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (stall_phase[7:6] == 2'b00) i_m_tready <= 1'b1;
        else if (stall_phase[7:6] == 2'b01) i_m_tready <= stall_phase[2];
        else i_m_tready <= ($urandom_range(0, 3) != 0);
    end

    // monitor: accept inputs into the predictor, check results
    t_answer got;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            in_taken <= i_s_tvalid && o_s_tready;
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (i_s_tvalid && o_s_tready) begin
                predict_word(pending_words.pop_front());
            end
            if (o_m_tvalid && i_m_tready) begin
                got.kind = o_m_tuser;
                got.found = o_m_tdata[0];
                got.count = o_m_tdata[11:1];
                got.ovf = o_m_tdata[12];
                if (expected_answers.size() == 0) begin
                    $display("%0t unexpected word: got %h", $time, got);
                    errors++;
                end else begin
                    if (got !== expected_answers[0]) begin
                        $display("%0t mismatch: expected kind %b found %b count %0d ovf %b,",
                            $time, expected_answers[0].kind, expected_answers[0].found,
                            expected_answers[0].count, expected_answers[0].ovf);
                        $display("    actual kind %b found %b count %0d ovf %b",
                            got.kind, got.found, got.count, got.ovf);
                        errors++;
                    end
                    void'(expected_answers.pop_front());
                end
            end
            // a full-table sort runs long with no handshake, hence the large idle limit
            if (idle_cycles > 3000000) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    logic [31:0] pool[$];
    int n_items;
    int tbl_len;

    initial begin
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = 1'b0;
        i_s_tlast = 1'b0;
        i_m_tready = 1'b0;
        stall_phase = 0;
        burst_left = 0;
        gap_left = 0;
        errors = 0;
        hold_off = 1'b0;
        in_taken = 1'b0;
        idle_cycles = 0;
        tbl_cnt = 0;
        tbl_ovf = 1'b0;
        tbl_open = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: query before any load, single entry, extremes, duplicates
        add_word(OP_QUERY, 32'h0, 1'b0);
        add_word(OP_LOAD, 32'h7fff_ffff, 1'b1);
        add_word(OP_QUERY, 32'h7fff_ffff, 1'b1);
        add_word(OP_QUERY, 32'h8000_0000, 1'b0);
        add_word(OP_LOAD, 32'h7fff_ffff, 1'b0);
        add_word(OP_LOAD, 32'h8000_0000, 1'b0);
        add_word(OP_LOAD, 32'hffff_ffff, 1'b0);
        add_word(OP_LOAD, 32'h0, 1'b0);
        add_word(OP_LOAD, 32'h0, 1'b1);
        add_word(OP_QUERY, 32'h8000_0000, 1'b0);
        add_word(OP_QUERY, 32'hffff_ffff, 1'b0);
        add_word(OP_QUERY, 32'h0000_0001, 1'b0);
        add_word(OP_QUERY, 32'h7fff_fffe, 1'b0);
        // query while a table is still open sorts it silently
        add_word(OP_LOAD, 32'h5, 1'b0);
        add_word(OP_LOAD, 32'h3, 1'b0);
        add_word(OP_QUERY, 32'h3, 1'b0);
        add_word(OP_QUERY, 32'h4, 1'b0);

        // pause until everything drained
        wait (pending_words.size() == 0);
        hold_off = 1'b1;
        wait (expected_answers.size() == 0);
        @(negedge i_clk);
        hold_off = 1'b0;

        // random: small tables, queries mostly on loaded values
        n_items = 0;
        while (n_items < 480) begin
            pool.delete();
            tbl_len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
            for (int i = 0; i < tbl_len; i++) begin
                pool.push_back(pick_value(pool));
                add_word(OP_LOAD, pool[$], (i == tbl_len - 1) && $urandom_range(0, 4) != 0);
            end
            repeat ($urandom_range(1, 10))
                add_word(OP_QUERY, pick_value(pool), 1'($urandom_range(0, 1)));
            n_items += tbl_len + 5;
        end

        wait (pending_words.size() == 0 && expected_answers.size() == 0);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && expected_answers.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ files.f @@
sv/stm_pkg.sv
sv/stm_ram.sv
sv/stm_ctrl.sv
sv/stm_dp.sv
sv/sorted_table_membership_search.sv
sim/tb_sorted_table_membership_search.sv
